// File: sv/mi3_pkg.sv
// Shared widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module of the block.
package mi3_pkg;

  // Element, product and cofactor widths.
  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;

  // Determinant terms and sum; the magnitude of the sum fits DMAG_W bits.
  localparam int TERM_W = ELEM_W + MAG_W + 2;
  localparam int DET_W  = TERM_W + 1;
  localparam int DMAG_W = DET_W - 2;

  // Divider: one quotient bit per stage, plus a rounding carry bit.
  localparam int QSTEPS = ELEM_W + 1;
  localparam int Q_W    = QSTEPS + 1;
  localparam int REM_W  = DMAG_W + QSTEPS;

  // Lane count and pipeline stage counts.
  localparam int LANES    = 9;
  localparam int FRONT_ST = 7;
  localparam int LANE_ST  = QSTEPS + 3;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // Determinant facts shared by all lanes.
  typedef struct packed {
    logic [DMAG_W-1:0] dmag;
    logic              dneg;
    logic              sing;
  } det_info_t;

endpackage

// File: sv/mi3_front.sv
// Front end: element products, cofactors and the determinant, seven stages.
// Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; (
  input  logic                        clk,
  input  logic                        adv,
  input  elem_t                       a [3][3],
  output det_info_t                   det_info,
  output logic [LANES-1:0][MAG_W-1:0] cmag,
  output logic [LANES-1:0]            cneg
);

  logic signed [PROD_W-1:0] p0 [3][3];
  logic signed [PROD_W-1:0] s0 [3][3];
  elem_t                    c0a [3];
  elem_t                    c1a [3];
  logic signed [COF_W-1:0]  cof1 [3][3];
  logic signed [COF_W-1:0]  cof2 [3][3];
  logic signed [COF_W-1:0]  cof3 [3][3];
  logic signed [COF_W-1:0]  cof4 [3][3];
  logic [PROD_W-1:0]        pl2 [3];
  logic [PROD_W-1:0]        ph2 [3];
  logic                     tn2 [3];
  logic                     tn3 [3];
  logic [PROD_W-1:0]        pl3 [3];
  logic [PROD_W-1:0]        ph3 [3];
  logic signed [TERM_W-1:0] t4 [3];
  logic signed [DET_W-1:0]  det5;
  logic signed [COF_W-1:0]  cof5 [3][3];
  logic [ELEM_W-1:0]        em [3];
  logic [COF_W-1:0]         cabs [3];
  logic [TERM_W-1:0]        tu [3];
  logic [COF_W-1:0]         oabs [LANES];
  logic [DET_W-1:0]         dabs;

  // Stage 0: the eighteen element products of the 2x2 minors.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c0a[i] <= a[i][0];
        for (int j = 0; j < 3; j++) begin
          p0[i][j] <= a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3];
          s0[i][j] <= a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        end
      end
    end
  end

  // Stage 1: exact cofactors.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c1a[i] <= c0a[i];
        for (int j = 0; j < 3; j++) begin
          cof1[i][j] <= COF_W'(p0[i][j]) - COF_W'(s0[i][j]);
        end
      end
    end
  end

  // Stage 2: first-column terms split into two 32x32 partial products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      em[i]   = c1a[i][ELEM_W-1] ? ELEM_W'(-c1a[i]) : ELEM_W'(c1a[i]);
      cabs[i] = cof1[i][0][COF_W-1] ? COF_W'(-cof1[i][0]) : COF_W'(cof1[i][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pl2[i] <= em[i] * cabs[i][ELEM_W-1:0];
        ph2[i] <= em[i] * cabs[i][MAG_W-1:ELEM_W];
        tn2[i] <= c1a[i][ELEM_W-1] ^ cof1[i][0][COF_W-1];
      end
      cof2 <= cof1;
    end
  end

  // Stage 3: hold the partial products one more stage before the wide add.
  always_ff @(posedge clk) begin
    if (adv) begin
      pl3  <= pl2;
      ph3  <= ph2;
      tn3  <= tn2;
      cof3 <= cof2;
    end
  end

  // Stage 4: signed determinant terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tu[i] = {2'b00, ph3[i], {ELEM_W{1'b0}}} + TERM_W'(pl3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t4[i] <= tn3[i] ? -tu[i] : tu[i];
      end
      cof4 <= cof3;
    end
  end

  // Stage 4b: the determinant sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      det5 <= DET_W'(t4[0]) + DET_W'(t4[1]) + DET_W'(t4[2]);
      cof5 <= cof4;
    end
  end

  // Stage 5: magnitudes and signs for the lanes (adjugate is the transpose).
  always_comb begin
    dabs = det5[DET_W-1] ? DET_W'(-det5) : DET_W'(det5);
    for (int k = 0; k < LANES; k++) begin
      oabs[k] = cof5[k/3][k%3][COF_W-1] ? COF_W'(-cof5[k/3][k%3])
                                        : COF_W'(cof5[k/3][k%3]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_info.dmag <= dabs[DMAG_W-1:0];
      det_info.dneg <= det5[DET_W-1];
      det_info.sing <= (det5 == '0);
      for (int k = 0; k < LANES; k++) begin
        cmag[k] <= oabs[k][MAG_W-1:0];
        cneg[k] <= cof5[k/3][k%3][COF_W-1];
      end
    end
  end

endmodule

// File: sv/mi3_lane.sv
// One output lane: pipelined restoring divide of a cofactor by the determinant,
// rounding, sign and saturation. Depends on mi3_pkg.
module mi3_lane import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [MAG_W-1:0]  cmag,
  input  logic              cneg,
  input  det_info_t         det_info,
  input  logic [DMAG_W-1:0] dstage [QSTEPS+1],
  output elem_t             value,
  output logic              sat
);

  localparam int QS_W = MAG_W + 1;
  localparam int RS   = QSTEPS + 1;
  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << (ELEM_W - 1);
  localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - Q_W'(1);

  logic [REM_W-1:0] r   [RS+1];
  logic [Q_W-1:0]   q   [RS+1];
  logic             ovf [RS+1];
  logic             neg [RS+1];
  logic             byp [RS+1];

  logic [REM_W-1:0] num;
  logic [REM_W-1:0] dlim;
  logic [QS_W-1:0]  qs;
  logic             up;
  logic [Q_W-1:0]   lim;
  logic             over;
  logic [Q_W-1:0]   mag;

  // Setup: scaled numerator, early overflow test, and the singular result.
  always_comb begin
    num  = REM_W'(cmag) << (2 * FRAC_BITS);
    dlim = REM_W'(det_info.dmag) << QSTEPS;
    qs   = (QS_W'(cmag) + (QS_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r[0]   <= num;
      q[0]   <= det_info.sing ? qs[Q_W-1:0] : '0;
      ovf[0] <= det_info.sing ? (|qs[QS_W-1:Q_W]) : (num >= dlim);
      neg[0] <= det_info.sing ? cneg : (cneg ^ det_info.dneg);
      byp[0] <= det_info.sing;
    end
  end

  // Divider: each stage settles one quotient bit, most significant first.
  for (genvar j = 1; j <= QSTEPS; j++) begin : g_step
    localparam int SH = QSTEPS - j;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = REM_W'(dstage[j-1]) << SH;
      take  = !byp[j-1] && (r[j-1] >= trial);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r[j]   <= take ? (r[j-1] - trial) : r[j-1];
        q[j]   <= q[j-1] | (take ? (Q_W'(1) << SH) : '0);
        ovf[j] <= ovf[j-1];
        neg[j] <= neg[j-1];
        byp[j] <= byp[j-1];
      end
    end
  end

  // Round to nearest, ties away from zero.
  assign up = !byp[QSTEPS] && ((r[QSTEPS] << 1) >= REM_W'(dstage[QSTEPS]));

  always_ff @(posedge clk) begin
    if (adv) begin
      r[RS]   <= r[QSTEPS];
      q[RS]   <= q[QSTEPS] + Q_W'(up);
      ovf[RS] <= ovf[QSTEPS];
      neg[RS] <= neg[QSTEPS];
      byp[RS] <= byp[QSTEPS];
    end
  end

  // Clip to the signed range and apply the sign.
  always_comb begin
    lim  = neg[RS] ? LIM_NEG : LIM_POS;
    over = ovf[RS] || (q[RS] > lim);
    mag  = over ? lim : q[RS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value <= neg[RS] ? elem_t'(-mag[ELEM_W-1:0]) : elem_t'(mag[ELEM_W-1:0]);
      sat   <= over;
    end
  end

endmodule

// File: sv/mat3_inverse_top.sv
// Top level of the 3x3 matrix inverse: front end, nine divider lanes, output merge.
// Depends on mi3_pkg, mi3_front and mi3_lane.
//
// Takes one 3x3 Q16.16 matrix per request and returns its inverse (adjugate over
// determinant), or the plain adjugate with singular set when the determinant is
// zero; saturated reports any clipped element. One matrix is accepted every
// cycle while req_stall is low. The path from an accepted request to rsp_valid
// runs through seven front stages (products, cofactors, the determinant terms,
// the determinant sum, magnitudes), then 36 stages per lane, set by the restoring
// divider that resolves one of 33 quotient bits per stage, and the output
// register. A skid register behind the output keeps the pipeline moving when
// rsp_stall rises, until a result must wait in it; req_stall follows that skid
// register, and no request is accepted while that register drains after a stall.
module mat3_inverse_top import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  elem_t in_r1c1,
  input  elem_t in_r2c1,
  input  elem_t in_r3c1,
  input  elem_t in_r1c2,
  input  elem_t in_r2c2,
  input  elem_t in_r3c2,
  input  elem_t in_r1c3,
  input  elem_t in_r2c3,
  input  elem_t in_r3c3,
  output logic  rsp_valid,
  input  logic  rsp_stall,
  output elem_t inv_r1c1,
  output elem_t inv_r2c1,
  output elem_t inv_r3c1,
  output elem_t inv_r1c2,
  output elem_t inv_r2c2,
  output elem_t inv_r3c2,
  output elem_t inv_r1c3,
  output elem_t inv_r2c3,
  output elem_t inv_r3c3,
  output logic  singular,
  output logic  saturated
);

  localparam int NST = FRONT_ST + LANE_ST;

  elem_t                       a [3][3];
  det_info_t                   det_info;
  logic [LANES-1:0][MAG_W-1:0] cmag;
  logic [LANES-1:0]            cneg;
  logic [DMAG_W-1:0]           dstage [QSTEPS+1];
  logic [LANE_ST-1:0]          sing_p;
  elem_t                       lane_val [LANES];
  logic [LANES-1:0]            lane_sat;
  logic [NST-1:0]              vld;
  logic                        adv;
  logic                        incoming;

  elem_t main_val [LANES];
  logic  main_sing;
  logic  main_sat;
  elem_t skid_val [LANES];
  logic  skid_sing;
  logic  skid_sat;
  logic  skid_full;

  // Matrix elements by row and column.
  always_comb begin
    a[0][0] = in_r1c1;
    a[1][0] = in_r2c1;
    a[2][0] = in_r3c1;
    a[0][1] = in_r1c2;
    a[1][1] = in_r2c2;
    a[2][1] = in_r3c2;
    a[0][2] = in_r1c3;
    a[1][2] = in_r2c3;
    a[2][2] = in_r3c3;
  end

  // The whole pipeline moves while the skid register is empty.
  assign adv       = !skid_full;
  assign req_stall = skid_full;
  assign incoming  = adv && vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], req_valid};
    end
  end

  mi3_front u_front (
    .clk      (clk),
    .adv      (adv),
    .a        (a),
    .det_info (det_info),
    .cmag     (cmag),
    .cneg     (cneg)
  );

  // Determinant magnitude and singular flag travel beside the lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      dstage[0] <= det_info.dmag;
      for (int j = 1; j <= QSTEPS; j++) begin
        dstage[j] <= dstage[j-1];
      end
      sing_p <= {sing_p[LANE_ST-2:0], det_info.sing};
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mi3_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .adv      (adv),
      .cmag     (cmag[k]),
      .cneg     (cneg[k]),
      .det_info (det_info),
      .dstage   (dstage),
      .value    (lane_val[k]),
      .sat      (lane_sat[k])
    );
  end

  // Merge the lanes into the output register, with a skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (rsp_valid && rsp_stall) begin
      if (incoming) begin
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      rsp_valid <= 1'b1;
      skid_full <= 1'b0;
    end else begin
      rsp_valid <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_stall) begin
      if (incoming) begin
        skid_val  <= lane_val;
        skid_sing <= sing_p[LANE_ST-1];
        skid_sat  <= |lane_sat;
      end
    end else if (skid_full) begin
      main_val  <= skid_val;
      main_sing <= skid_sing;
      main_sat  <= skid_sat;
    end else if (incoming) begin
      main_val  <= lane_val;
      main_sing <= sing_p[LANE_ST-1];
      main_sat  <= |lane_sat;
    end
  end

  assign inv_r1c1  = main_val[0];
  assign inv_r2c1  = main_val[1];
  assign inv_r3c1  = main_val[2];
  assign inv_r1c2  = main_val[3];
  assign inv_r2c2  = main_val[4];
  assign inv_r3c2  = main_val[5];
  assign inv_r1c3  = main_val[6];
  assign inv_r2c3  = main_val[7];
  assign inv_r3c3  = main_val[8];
  assign singular  = main_sing;
  assign saturated = main_sat;

`ifndef NO_ASSERTIONS
  // An accepted request always occupies the first stage next cycle.
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  // The skid slot only fills behind a held output.
  a_skid_behind : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> rsp_valid)
    else $error("skid register full with empty output register");

  // A taken result with nothing behind it leaves the output empty.
  a_drain : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !skid_full && !vld[NST-1] |=> !rsp_valid)
    else $error("output stayed valid without a new result");
`endif

endmodule
